/* rtl/biquad_to_svf_coefficients_assert.svh */
// Assertion macros used by the checker file of the coefficient converter.
// No dependencies; included by bare file name.
`ifndef BIQUAD_TO_SVF_COEFFICIENTS_ASSERT_SVH
`define BIQUAD_TO_SVF_COEFFICIENTS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BQ2S_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BQ2S_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bq2s_pkg.sv */
// Shared constants, types and the saturation function of the coefficient converter.
// No dependencies.
package bq2s_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned CHUNK_W       = 16;   // multiplier slice per pipeline stage
  localparam int unsigned SAT_W         = 128;  // widest magnitude fed to saturation

  typedef struct packed {
    logic mute;
    logic hp_neg;
    logic bp_neg;
    logic lp_neg;
    logic g_neg;
    logic r_neg;
  } flags_t;

  typedef struct packed {
    logic [COEF_W-1:0] v;
    logic              ovf;
  } sat_t;

  // Clamp a sign/magnitude value to signed 32 bits; big forces saturation.
  function automatic sat_t sat32(input logic neg, input logic big,
                                 input logic [SAT_W-1:0] m);
    sat_t r;
    logic lim;
    lim = neg ? (m > SAT_W'(33'h0_8000_0000)) : (m > SAT_W'(33'h0_7FFF_FFFF));
    if (big || lim) begin
      r.v   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else begin
      r.v   = neg ? (32'd0 - m[COEF_W-1:0]) : m[COEF_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/bq2s_delay.sv */
// Enable-gated shift line that carries valid bits and sideband data past a unit.
// No dependencies.
module bq2s_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);
  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < N; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign d_o = line_q[N-1];
endmodule

/* rtl/bq2s_mul.sv */
// Pipelined unsigned multiplier: one CHUNK_W-bit slice of b per stage.
// Depends on bq2s_pkg.
module bq2s_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);
  localparam int unsigned CH  = bq2s_pkg::CHUNK_W;
  localparam int unsigned NS  = (BW + CH - 1) / CH;
  localparam int unsigned BPW = NS * CH;
  localparam int unsigned PXW = AW + BPW;

  logic [AW-1:0]  a_q   [NS];
  logic [BPW-1:0] b_q   [NS];
  logic [PXW-1:0] acc_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [AW-1:0]    a_prev;
    logic [BPW-1:0]   b_prev;
    logic [PXW-1:0]   acc_prev;
    logic [AW+CH-1:0] pp;
    if (k == 0) begin : g_first
      assign a_prev   = a_i;
      assign b_prev   = BPW'(b_i);
      assign acc_prev = '0;
    end else begin : g_next
      assign a_prev   = a_q[k-1];
      assign b_prev   = b_q[k-1];
      assign acc_prev = acc_q[k-1];
    end
    assign pp = a_prev * b_prev[k*CH +: CH];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_prev;
        b_q[k]   <= b_prev;
        acc_q[k] <= acc_prev + (PXW'(pp) << (k * CH));
      end
    end
  end

  assign p_o = acc_q[NS-1][AW+BW-1:0];
endmodule

/* rtl/bq2s_sqrt.sv */
// Pipelined integer square root, one result bit per stage (floor).
// No dependencies.
module bq2s_sqrt #(
  parameter int unsigned RW = 57
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] x_i,
  output logic [RW-1:0]   root_o
);
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] x_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] x_prev;
    logic [RW+3:0]   tmp;
    logic [RW+3:0]   trial;
    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign x_prev    = x_i;
    end else begin : g_next
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign x_prev    = x_q[k-1];
    end
    assign tmp   = {rem_prev, x_prev[2*RW-1 -: 2]};
    assign trial = {2'b00, root_prev, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= x_prev << 2;
        if (tmp >= trial) begin
          rem_q[k]  <= (RW+2)'(tmp - trial);
          root_q[k] <= {root_prev[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= tmp[RW+1:0];
          root_q[k] <= {root_prev[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RW-1];
endmodule

/* rtl/bq2s_div.sv */
// Pipelined restoring divider: QW quotient bits, one per stage, after a range check.
// No dependencies.
module bq2s_div #(
  parameter int unsigned NW = 57,
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          ovf_o   // quotient does not fit in QW bits
);
  localparam int unsigned TW = QW + DW;

  logic [TW-1:0] nx;
  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];

  assign nx = TW'(n_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= nx[TW-1:QW] >= d_i;
      rem_q[0] <= nx[TW-1:QW];
      low_q[0] <= nx[QW-1:0];
      d_q[0]   <= d_i;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] tmp;
    logic        take;
    assign tmp  = {rem_q[k-1], low_q[k-1][QW-1]};
    assign take = tmp >= {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DW'(tmp - {1'b0, d_q[k-1]}) : tmp[DW-1:0];
        low_q[k] <= low_q[k-1] << 1;
        d_q[k]   <= d_q[k-1];
        q_q[k]   <= {q_q[k-1][QW-2:0], take};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];
endmodule

/* rtl/biquad_to_svf_coefficients.sv */
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   num0, num1, num2, den1, den2 (32 bits each) / -
// m_axis    out  hp_mix, bp_mix, lp_mix, integ_gain, feedback_coef, norm_scale / muted, overflow
//
// One item per cycle while the skid register is empty. Stages in order: input register, p*q
// multiplier, square root and first division bank (one bit per stage each), stage C register,
// g*c multiplier, stage D register, normalizer divider, output register. Reset clears all valid bits.
// A stalled output is held; the next result goes to a skid register and the whole
// pipeline freezes while that register is full.
// Depends on bq2s_pkg, bq2s_delay, bq2s_mul, bq2s_sqrt, bq2s_div.
module biquad_to_svf_coefficients #(
  parameter int unsigned FRAC_BITS = bq2s_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [159:0] s_axis_tdata_i,   // num0, num1, num2, den1, den2
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [191:0] m_axis_tdata_o,   // hp_mix, bp_mix, lp_mix, integ_gain,
                                         // feedback_coef, norm_scale
  output logic [1:0]   m_axis_tuser_o    // muted, overflow
);
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned CW32  = bq2s_pkg::COEF_W;
  localparam int unsigned SATW  = bq2s_pkg::SAT_W;
  localparam int unsigned CH    = bq2s_pkg::CHUNK_W;
  localparam int unsigned PW    = 33;
  localparam int unsigned RW    = 33 + F;
  localparam int unsigned XW    = 2 * RW;
  localparam int unsigned NHW   = 33 + F;
  localparam int unsigned NBW   = 33 + 2 * F;
  localparam int unsigned QW1   = 34 + F;
  localparam int unsigned CMW   = QW1 + 1;
  localparam int unsigned MW    = QW1 + CMW;
  localparam int unsigned DENW  = MW + 1;
  localparam int unsigned NSW   = 3 * F + 1;
  localparam int unsigned QW2   = 32;
  localparam int unsigned NS_PQ = (PW + CH - 1) / CH;
  localparam int unsigned NS_GC = (CMW + CH - 1) / CH;
  localparam logic signed [33:0] ONE = 34'(1) << F;

  typedef struct packed {
    logic             valid;
    bq2s_pkg::flags_t fl;
    logic [PW-1:0]    p;
    logic [PW-1:0]    q;
    logic [NHW-1:0]   hpn;
    logic [NHW-1:0]   lpn;
    logic [NBW-1:0]   bpn;
    logic [NBW-1:0]   rn;
  } s1_t;

  typedef struct packed {
    logic             valid;
    bq2s_pkg::flags_t fl;
  } s2_t;

  typedef struct packed {
    logic            valid;
    logic            mute;
    logic            pneg;
    logic [CW32-1:0] hp;
    logic [CW32-1:0] bp;
    logic [CW32-1:0] lp;
    logic [CW32-1:0] g;
    logic [CW32-1:0] c;
    logic            ovf;
  } s3_t;

  typedef struct packed {
    s3_t  b;
    logic dneg;
    logic dzero;
  } s4_t;

  logic pipe_en;

  // ---------------- stage A: differences, signs, magnitudes
  logic signed [33:0] b0, b1, b2, a1, a2, t1, t2, nh, nl, db, e;
  logic [33:0] t1m, t2m, nhm, nlm, dbm, em;
  logic t1_pos, t2_pos;
  s1_t s1_d, s1_q;

  assign b0 = 34'(signed'(s_axis_tdata_i[31:0]));
  assign b1 = 34'(signed'(s_axis_tdata_i[63:32]));
  assign b2 = 34'(signed'(s_axis_tdata_i[95:64]));
  assign a1 = 34'(signed'(s_axis_tdata_i[127:96]));
  assign a2 = 34'(signed'(s_axis_tdata_i[159:128]));
  assign t1 = a1 - a2 - ONE;
  assign t2 = a1 + a2 + ONE;
  assign nh = b1 - b0 - b2;
  assign nl = b1 + b0 + b2;
  assign db = b0 - b2;
  assign e  = a2 - ONE;
  assign t1m = t1[33] ? -t1 : t1;
  assign t2m = t2[33] ? -t2 : t2;
  assign nhm = nh[33] ? -nh : nh;
  assign nlm = nl[33] ? -nl : nl;
  assign dbm = db[33] ? -db : db;
  assign em  = e[33] ? -e : e;
  assign t1_pos = !t1[33] && (t1 != '0);
  assign t2_pos = !t2[33] && (t2 != '0);

  always_comb begin
    s1_d.valid     = s_axis_tvalid_i;
    s1_d.fl.mute   = (t1 == '0) || (t2 == '0) || (t1_pos == t2_pos);
    s1_d.fl.hp_neg = nh[33] != t1[33];
    s1_d.fl.lp_neg = nl[33] != t2[33];
    s1_d.fl.bp_neg = db[33];
    s1_d.fl.g_neg  = t1_pos;
    s1_d.fl.r_neg  = !e[33] && (e != '0);
    s1_d.p   = t1m[PW-1:0];
    s1_d.q   = t2m[PW-1:0];
    s1_d.hpn = NHW'(nhm[32:0]) << F;
    s1_d.lpn = NHW'(nlm[32:0]) << F;
    s1_d.bpn = NBW'({dbm[31:0], 1'b0}) << (2 * F);
    s1_d.rn  = NBW'({em[31:0], 1'b0}) << (2 * F);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
    end else if (pipe_en) begin
      s1_q <= s1_d;
    end
  end

  // ---------------- p*q, then W = sqrt(p*q) scaled by one
  logic [2*PW-1:0] pq;
  logic [RW-1:0]   w;
  s1_t s1_dl;

  bq2s_mul #(.AW(PW), .BW(PW)) u_mul_pq (
    .clk_i, .en_i(pipe_en), .a_i(s1_q.p), .b_i(s1_q.q), .p_o(pq)
  );

  bq2s_sqrt #(.RW(RW)) u_sqrt (
    .clk_i, .en_i(pipe_en), .x_i(XW'(pq) << (2 * F)), .root_o(w)
  );

  bq2s_delay #(.W($bits(s1_t)), .N(NS_PQ + RW)) u_dly_s1 (
    .clk_i, .rst_ni, .en_i(pipe_en), .d_i(s1_q), .d_o(s1_dl)
  );

  // ---------------- first division bank
  logic [QW1-1:0] hp_q, lp_q, bp_q, g_q, r_q;
  logic           hp_ov, lp_ov, bp_ov, g_ov, r_ov;
  s2_t s2_d, s2_dl;

  bq2s_div #(.NW(NHW), .DW(PW), .QW(QW1)) u_div_hp (
    .clk_i, .en_i(pipe_en), .n_i(s1_dl.hpn), .d_i(s1_dl.p), .q_o(hp_q), .ovf_o(hp_ov)
  );
  bq2s_div #(.NW(NHW), .DW(PW), .QW(QW1)) u_div_lp (
    .clk_i, .en_i(pipe_en), .n_i(s1_dl.lpn), .d_i(s1_dl.q), .q_o(lp_q), .ovf_o(lp_ov)
  );
  bq2s_div #(.NW(NBW), .DW(RW), .QW(QW1)) u_div_bp (
    .clk_i, .en_i(pipe_en), .n_i(s1_dl.bpn), .d_i(w), .q_o(bp_q), .ovf_o(bp_ov)
  );
  bq2s_div #(.NW(RW), .DW(PW), .QW(QW1)) u_div_g (
    .clk_i, .en_i(pipe_en), .n_i(w), .d_i(s1_dl.p), .q_o(g_q), .ovf_o(g_ov)
  );
  bq2s_div #(.NW(NBW), .DW(RW), .QW(QW1)) u_div_r (
    .clk_i, .en_i(pipe_en), .n_i(s1_dl.rn), .d_i(w), .q_o(r_q), .ovf_o(r_ov)
  );

  assign s2_d.valid = s1_dl.valid;
  assign s2_d.fl    = s1_dl.fl;

  bq2s_delay #(.W($bits(s2_t)), .N(QW1 + 1)) u_dly_s2 (
    .clk_i, .rst_ni, .en_i(pipe_en), .d_i(s2_d), .d_o(s2_dl)
  );

  // ---------------- stage C: c = g + r, saturate five coefficients
  logic [CMW-1:0] cm;
  logic           nc;
  bq2s_pkg::sat_t hp_s, bp_s, lp_s, g_s, c_s;
  s3_t            s3_d, s3_q, s3_dl;
  logic [QW1-1:0] gm_q;
  logic [CMW-1:0] cm_q;

  always_comb begin
    if (s2_dl.fl.g_neg == s2_dl.fl.r_neg) begin
      cm = CMW'(g_q) + CMW'(r_q);
      nc = s2_dl.fl.g_neg;
    end else if (g_q >= r_q) begin
      cm = CMW'(g_q - r_q);
      nc = s2_dl.fl.g_neg;
    end else begin
      cm = CMW'(r_q - g_q);
      nc = s2_dl.fl.r_neg;
    end
    hp_s = bq2s_pkg::sat32(s2_dl.fl.hp_neg, hp_ov, SATW'(hp_q));
    bp_s = bq2s_pkg::sat32(s2_dl.fl.bp_neg, bp_ov, SATW'(bp_q));
    lp_s = bq2s_pkg::sat32(s2_dl.fl.lp_neg, lp_ov, SATW'(lp_q));
    g_s  = bq2s_pkg::sat32(s2_dl.fl.g_neg, g_ov, SATW'(g_q));
    c_s  = bq2s_pkg::sat32(nc, r_ov, SATW'(cm));
    s3_d.valid = s2_dl.valid;
    s3_d.mute  = s2_dl.fl.mute;
    s3_d.pneg  = s2_dl.fl.g_neg != nc;
    s3_d.hp    = hp_s.v;
    s3_d.bp    = bp_s.v;
    s3_d.lp    = lp_s.v;
    s3_d.g     = g_s.v;
    s3_d.c     = c_s.v;
    s3_d.ovf   = hp_s.ovf | bp_s.ovf | lp_s.ovf | g_s.ovf | c_s.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q.valid <= 1'b0;
    end else if (pipe_en) begin
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      gm_q <= g_q;
      cm_q <= cm;
    end
  end

  // ---------------- g*c
  logic [MW-1:0] m;

  bq2s_mul #(.AW(QW1), .BW(CMW)) u_mul_gc (
    .clk_i, .en_i(pipe_en), .a_i(gm_q), .b_i(cm_q), .p_o(m)
  );

  bq2s_delay #(.W($bits(s3_t)), .N(NS_GC)) u_dly_s3 (
    .clk_i, .rst_ni, .en_i(pipe_en), .d_i(s3_q), .d_o(s3_dl)
  );

  // ---------------- stage D: denominator 1 + g*c as sign and magnitude
  localparam logic [DENW-1:0] BASE = DENW'(1) << (2 * F);
  logic [DENW-1:0] den_d, den_q, mx;
  s4_t s4_d, s4_q, s4_dl;

  assign mx = DENW'(m);

  always_comb begin
    s4_d.b = s3_dl;
    if (!s3_dl.pneg) begin
      den_d     = BASE + mx;
      s4_d.dneg = 1'b0;
    end else if (mx <= BASE) begin
      den_d     = BASE - mx;
      s4_d.dneg = 1'b0;
    end else begin
      den_d     = mx - BASE;
      s4_d.dneg = 1'b1;
    end
    s4_d.dzero = den_d == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q.b.valid <= 1'b0;
    end else if (pipe_en) begin
      s4_q <= s4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) den_q <= den_d;
  end

  // ---------------- normalizer 1/(1+g*c)
  logic [QW2-1:0] ns_q;
  logic           ns_ov;

  bq2s_div #(.NW(NSW), .DW(DENW), .QW(QW2)) u_div_ns (
    .clk_i, .en_i(pipe_en), .n_i(NSW'(1) << (3 * F)), .d_i(den_q),
    .q_o(ns_q), .ovf_o(ns_ov)
  );

  bq2s_delay #(.W($bits(s4_t)), .N(QW2 + 1)) u_dly_s4 (
    .clk_i, .rst_ni, .en_i(pipe_en), .d_i(s4_q), .d_o(s4_dl)
  );

  // ---------------- stage E: final result, output register and skid
  bq2s_pkg::sat_t ns_s;
  logic [191:0]   e_data;
  logic [1:0]     e_user;
  logic           e_valid;

  always_comb begin
    ns_s = bq2s_pkg::sat32(s4_dl.dneg, ns_ov, SATW'(ns_q));
    if (s4_dl.dzero) begin
      ns_s.v   = 32'h7FFF_FFFF;
      ns_s.ovf = 1'b1;
    end
    if (s4_dl.b.mute) begin
      e_data = '0;
      e_user = 2'b01;
    end else begin
      e_data = {ns_s.v, s4_dl.b.c, s4_dl.b.g, s4_dl.b.lp, s4_dl.b.bp, s4_dl.b.hp};
      e_user = {s4_dl.b.ovf | ns_s.ovf, 1'b0};
    end
  end

  assign e_valid = s4_dl.b.valid;

  logic         out_valid_q, skid_valid_q;
  logic [191:0] out_data_q, skid_data_q;
  logic [1:0]   out_user_q, skid_user_q;
  logic         take;

  assign take    = out_valid_q && m_axis_tready_i;
  assign pipe_en = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain the skid once the held result is taken
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= e_valid;
    end else if (e_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (!out_valid_q || take) begin
      out_data_q <= e_data;
      out_user_q <= e_user;
    end else if (e_valid) begin
      skid_data_q <= e_data;
      skid_user_q <= e_user;
    end
  end

  assign s_axis_tready_o = pipe_en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
endmodule

/* rtl/bq2s_checker.sv */
// Port-level checks on the coefficient converter, bound to its top level.
// Depends on biquad_to_svf_coefficients_assert.svh.
module bq2s_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [159:0] s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);
  `include "biquad_to_svf_coefficients_assert.svh"

  // a muted result carries zero coefficients and never flags saturation
  `BQ2S_ASSERT_IMP(a_muted_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0 && !m_axis_tuser_o[1], "muted result not zero")

  // a stalled output transfer holds
  `BQ2S_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled output changed")

  // a waiting input transfer holds its data
  `BQ2S_ASSERT_NXT(a_in_hold, clk_i, rst_ni, s_axis_tvalid_i && !s_axis_tready_o, s_axis_tvalid_i && $stable(s_axis_tdata_i), "waiting input changed")

  // input side backs off only after an output stall
  `BQ2S_ASSERT_IMP(a_ready_drop, clk_i, rst_ni, $fell(s_axis_tready_o), $past(m_axis_tvalid_o && !m_axis_tready_i), "input ready dropped without output stall")
endmodule

bind biquad_to_svf_coefficients bq2s_checker u_bq2s_checker (.*);

/* test/tb_biquad_to_svf_coefficients.sv */
// Testbench for biquad_to_svf_coefficients: drives coefficient sets, predicts the
// state variable filter coefficients in wide integer math and checks every result.
// Depends on bq2s_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_biquad_to_svf_coefficients;

  localparam int FB = bq2s_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int STALL_LIMIT = 5000;
  localparam int RUN_LIMIT = 200000;
  localparam int N_RANDOM = 880;

  typedef struct {
    logic [159:0] data;
    bit           drain;   // hold off until every pending result is back
  } coef_set_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;   // num0, num1, num2, den1, den2
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [191:0] m_axis_tdata_o;        // hp_mix, bp_mix, lp_mix, integ_gain,
                                       // feedback_coef, norm_scale
  logic [1:0]   m_axis_tuser_o;        // muted, overflow

  coef_set_t    sets_q[$];
  logic [191:0] svf_coef_q[$];
  logic [1:0]   svf_flag_q[$];
  int           n_sent = 0, n_checked = 0, n_errors = 0, n_muted = 0, n_ovf = 0;
  int           gap_cnt = 0, stall_cnt = 0, idle_cycles = 0, run_cycles = 0;
  bit           src_idle = 1'b1, sink_idle = 1'b1;

  biquad_to_svf_coefficients i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [255:0] mag(input longint v);
    return v < 0 ? 256'(-v) : 256'(v);
  endfunction

  function automatic logic [63:0] isqrt(input logic [255:0] x);
    logic [63:0]  y;
    logic [63:0]  c;
    logic [255:0] cc;
    y = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = y | (64'd1 << b);
      cc = {192'd0, c} * {192'd0, c};
      if (cc <= x) y = c;
    end
    return y;
  endfunction

  function automatic logic [31:0] clamp32(input bit neg, input logic [255:0] m,
                                          inout bit ovf);
    if (neg) begin
      if (m > 256'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'd0 - m[31:0];
    end
    if (m > 256'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  // Work out the filter coefficients and flags for one biquad set.
  function automatic void svf_coefs(input logic [159:0] d, output logic [191:0] co,
                                    output logic [1:0] fl);
    longint b0, b1, b2, a1, a2, t1, t2, nh, nl, db, e;
    logic [255:0] p, q, w, gm, rm, cm, m, base, den;
    bit ovf, ng, nr, nc, dneg;
    b0 = longint'($signed(d[31:0]));
    b1 = longint'($signed(d[63:32]));
    b2 = longint'($signed(d[95:64]));
    a1 = longint'($signed(d[127:96]));
    a2 = longint'($signed(d[159:128]));
    t1 = a1 - a2 - ONE;
    t2 = a1 + a2 + ONE;
    co = '0;
    ovf = 1'b0;
    if (t1 == 0 || t2 == 0 || (t1 > 0) == (t2 > 0)) begin
      fl = 2'b01;
      return;
    end
    p  = mag(t1);
    q  = mag(t2);
    w  = 256'(isqrt((p * q) << (2 * FB)));
    nh = b1 - b0 - b2;
    co[31:0] = clamp32((nh < 0) != (t1 < 0), (mag(nh) << FB) / p, ovf);
    db = b0 - b2;
    co[63:32] = clamp32(db < 0, ((2 * mag(db)) << (2 * FB)) / w, ovf);
    nl = b1 + b0 + b2;
    co[95:64] = clamp32((nl < 0) != (t2 < 0), (mag(nl) << FB) / q, ovf);
    ng = t1 > 0;
    gm = w / p;
    co[127:96] = clamp32(ng, gm, ovf);
    e  = a2 - ONE;
    nr = e > 0;
    rm = ((2 * mag(e)) << (2 * FB)) / w;
    if (ng == nr) begin
      cm = gm + rm;
      nc = ng;
    end else if (gm >= rm) begin
      cm = gm - rm;
      nc = ng;
    end else begin
      cm = rm - gm;
      nc = nr;
    end
    co[159:128] = clamp32(nc, cm, ovf);
    m    = gm * cm;
    base = 256'd1 << (2 * FB);
    dneg = 1'b0;
    if (ng == nc) den = base + m;
    else if (m <= base) den = base - m;
    else begin
      den  = m - base;
      dneg = 1'b1;
    end
    if (den == 0) begin
      ovf = 1'b1;
      co[191:160] = 32'h7FFF_FFFF;
    end else begin
      co[191:160] = clamp32(dneg, (256'd1 << (3 * FB)) / den, ovf);
    end
    fl = {ovf, 1'b0};
  endfunction

  function automatic logic [159:0] pack(input longint b0, b1, b2, a1, a2);
    return {a2[31:0], a1[31:0], b2[31:0], b1[31:0], b0[31:0]};
  endfunction

  function automatic longint rnd_range(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  // Stable biquad: |a2| < 1, |a1| < 1 + a2, numerator within a few units.
  function automatic logic [159:0] stable_set();
    longint a1, a2, lim;
    a2  = rnd_range(-ONE + 1, ONE - 1);
    lim = ONE + a2 - 1;
    a1  = rnd_range(-lim, lim);
    return pack(rnd_range(-4 * ONE, 4 * ONE), rnd_range(-4 * ONE, 4 * ONE),
                rnd_range(-4 * ONE, 4 * ONE), a1, a2);
  endfunction

  function automatic logic [159:0] raw_set();
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic int draw_wait(input bit idle_on);
    return idle_on ? int'($urandom_range(9, 0)) : 0;
  endfunction

  // Source side: present the next set after its drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [191:0] co;
    logic [1:0]   fl;
    bit           took;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      took = s_axis_tvalid_i && s_axis_tready_o;
      if (took) begin
        svf_coefs(s_axis_tdata_i, co, fl);
        svf_coef_q.push_back(co);
        svf_flag_q.push_back(fl);
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid_i || took) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (sets_q.size() > 0 &&
                     !(sets_q[0].drain && (took || n_sent != n_checked))) begin
          s_axis_tdata_i <= sets_q[0].data;
          s_axis_tvalid_i <= 1'b1;
          void'(sets_q.pop_front());
          if ($urandom_range(99, 0) < 2) src_idle <= !src_idle;
          gap_cnt <= draw_wait(src_idle);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each result transfer, then stall for a drawn count.
  always @(posedge clk_i or negedge rst_ni) begin
    string names[6];
    logic [191:0] co;
    logic [1:0]   fl;
    int           errs;
    names = '{"hp_mix", "bp_mix", "lp_mix", "integ_gain", "feedback_coef", "norm_scale"};
    errs = 0;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (n_checked == n_sent) begin
          $display("%0t: unexpected result %h / %b", $time, m_axis_tdata_o, m_axis_tuser_o);
          errs = errs + 1;
        end else begin
          co = svf_coef_q.pop_front();
          fl = svf_flag_q.pop_front();
          n_checked <= n_checked + 1;
          n_muted <= n_muted + fl[0];
          n_ovf <= n_ovf + fl[1];
          for (int k = 0; k < 6; k++) begin
            if (co[32*k +: 32] !== m_axis_tdata_o[32*k +: 32]) begin
              $display("%0t: %s expected %h actual %h", $time, names[k],
                       co[32*k +: 32], m_axis_tdata_o[32*k +: 32]);
              errs = errs + 1;
            end
          end
          if (fl !== m_axis_tuser_o) begin
            $display("%0t: muted/overflow expected %b actual %b", $time, fl, m_axis_tuser_o);
            errs = errs + 1;
          end
        end
        n_errors <= n_errors + errs;
        if ($urandom_range(99, 0) < 2) sink_idle <= !sink_idle;
        stall_cnt <= draw_wait(sink_idle);
        m_axis_tready_i <= !sink_idle;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer and on the overall run length.
  always @(posedge clk_i) begin
    run_cycles <= run_cycles + 1;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_set(input logic [159:0] d, input bit drain = 1'b0);
    coef_set_t s;
    s.data  = d;
    s.drain = drain;
    sets_q.push_back(s);
  endtask

  initial begin
    // Directed sets: extremes, both mute conditions, degenerate terms.
    add_set(pack(0, 0, 0, 0, 0));
    add_set(pack(ONE, 0, 0, 0, -ONE));                  // T1 = T2 = 0
    add_set(pack(ONE, 2 * ONE, ONE, 3 * ONE, 0));       // T1, T2 both positive
    add_set(pack(ONE, ONE, ONE, -3 * ONE, 0));          // T1, T2 both negative
    add_set(pack(ONE, ONE, ONE, ONE, 0));               // T1 = 0 only
    add_set(pack(ONE, -2 * ONE, ONE, -ONE / 2, ONE / 4));
    add_set(pack(ONE / 8, ONE / 4, ONE / 8, -ONE, ONE / 2));
    add_set(pack(ONE, 0, ONE, 0, ONE / 2));             // no bandpass
    add_set(pack(ONE, ONE, -ONE, ONE / 4, ONE));        // no damping term
    add_set(pack(ONE, 0, 0, 0, ONE - 1));
    add_set(pack(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    add_set(pack(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 0, 0));
    add_set(pack(32'h7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000, 1, -ONE + 1));
    add_set({5{32'h7FFF_FFFF}});
    add_set({5{32'h8000_0000}});
    add_set({32'h8000_0000, 32'h7FFF_FFFF, 96'h0}, 1'b1);
    add_set({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0});
    add_set(pack(ONE, 2 * ONE, ONE, 2 * ONE - 1, ONE - 1));
    add_set(pack(ONE, 2 * ONE, ONE, -2 * ONE + 1, ONE - 1));
    add_set({5{32'hFFFF_FFFF}});
    for (int i = 0; i < N_RANDOM; i++)
      add_set($urandom_range(99, 0) < 75 ? stable_set() : raw_set(),
              (i % 300) == 150);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sets_q.size() == 0 && !s_axis_tvalid_i && n_checked == n_sent);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d coefficient sets, checked %0d results (%0d muted, %0d saturated).",
             n_sent, n_checked, n_muted, n_ovf);
    if (n_errors == 0 && n_checked == n_sent)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bq2s_pkg.sv
rtl/bq2s_delay.sv
rtl/bq2s_mul.sv
rtl/bq2s_sqrt.sv
rtl/bq2s_div.sv
rtl/biquad_to_svf_coefficients.sv
rtl/bq2s_checker.sv
test/tb_biquad_to_svf_coefficients.sv
